// ----- sv/aspci_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aspci_pkg
// Shared types and constants of the ascii pin command interpreter.
// ----------------------------------------------------------------------------
package aspci_pkg;

   localparam int RESP_DEPTH_DEF = 63;
   localparam int CHAN_COUNT_DEF = 32;
   localparam int PIN_COUNT_DEF  = 64;

   // input operations
   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_CWRITE = 2'd2;
   localparam logic [1:0] OP_CREAD  = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_BYTE   = 3'd0;
   localparam logic [2:0] KIND_MODE   = 3'd1;
   localparam logic [2:0] KIND_DWRITE = 3'd2;
   localparam logic [2:0] KIND_PWM    = 3'd3;
   localparam logic [2:0] KIND_DREAD  = 3'd4;
   localparam logic [2:0] KIND_AREAD  = 3'd5;
   localparam logic [2:0] KIND_CHAN   = 3'd6;

   // characters
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_S_UP  = 8'h53;
   localparam logic [7:0] CH_S_LO  = 8'h73;
   localparam logic [7:0] CH_W_UP  = 8'h57;
   localparam logic [7:0] CH_W_LO  = 8'h77;
   localparam logic [7:0] CH_R_UP  = 8'h52;
   localparam logic [7:0] CH_R_LO  = 8'h72;
   localparam logic [7:0] CH_N_UP  = 8'h4E;
   localparam logic [7:0] CH_N_LO  = 8'h6E;
   localparam logic [7:0] PWM_MAX  = 8'd255;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         rx_byte;
      logic [9:0]         sample;
      logic [4:0]         chan_index;
      logic signed [15:0] chan_data;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [6:0]         pin;
      logic [7:0]         level;
      logic [7:0]         tx_byte;
      logic signed [15:0] chan_out;
      logic               truncated;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/aspci_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aspci_queue
// Two-entry queue between the input channel and the command executor.
// ----------------------------------------------------------------------------
module aspci_queue
   import aspci_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  req_type push_data,
   output logic    push_stall,
   output logic    pop_valid,
   output req_type pop_data,
   input  logic    pop
);

   localparam int DEPTH = 2;

   req_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_stall = (count_ff == 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- sv/aspci_bcd.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aspci_bcd
// Shift-and-add-three converter, one bit a cycle, 16 bits to five digits.
// ----------------------------------------------------------------------------
module aspci_bcd
   import aspci_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] value,
   output logic        done,
   output logic [19:0] digits
);

   logic [15:0] bin_ff, bin_in;
   logic [19:0] bcd_ff, bcd_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   assign done   = done_ff;
   assign digits = bcd_ff;

   always_comb begin
      logic [19:0] adj;
      adj     = bcd_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      for (int k = 0; k < 5; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end
      end
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[18:0], bin_ff, 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule
`default_nettype wire

// ----- sv/aspci_exec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aspci_exec
// Command parser and executor: response store, channel store, result register.
// ----------------------------------------------------------------------------
module aspci_exec
   import aspci_pkg::*;
#(
   parameter int RESP_DEPTH = RESP_DEPTH_DEF,
   parameter int CHAN_COUNT = CHAN_COUNT_DEF,
   parameter int PIN_COUNT  = PIN_COUNT_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  req_type     item,
   output logic        item_pop,
   input  logic [63:0] lock_mask,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        rsp_stall
);

   localparam int FW  = $clog2(RESP_DEPTH + 1);
   localparam int AW  = $clog2(RESP_DEPTH);
   localparam int CIW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
   localparam logic [5:0]    CC6   = 6'(CHAN_COUNT);
   localparam logic [FW-1:0] DEPTH = FW'(RESP_DEPTH);

   typedef enum logic [9:0] {
      PH_HDR   = 10'b0000000001,
      PH_SKIP  = 10'b0000000010,
      PH_CNT1  = 10'b0000000100,
      PH_CNT2  = 10'b0000001000,
      PH_PIN1  = 10'b0000010000,
      PH_PIN2  = 10'b0000100000,
      PH_MODE  = 10'b0001000000,
      PH_WVAL  = 10'b0010000000,
      PH_NSIGN = 10'b0100000000,
      PH_NVAL  = 10'b1000000000
   } phase_type;

   typedef enum logic [8:0] {
      XS_IDLE   = 9'b000000001,
      XS_APPEND = 9'b000000010,
      XS_CHRD   = 9'b000000100,
      XS_CONV   = 9'b000001000,
      XS_PATCH1 = 9'b000010000,
      XS_PATCH2 = 9'b000100000,
      XS_FLADDR = 9'b001000000,
      XS_FLDATA = 9'b010000000,
      XS_FLNL   = 9'b100000000
   } xstate_type;

   typedef enum logic [1:0] {
      CMD_S = 2'd0,
      CMD_W = 2'd1,
      CMD_R = 2'd2,
      CMD_N = 2'd3
   } cmd_type;

   phase_type   phase_ff, phase_in;
   xstate_type  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [16:0] acc_ff, acc_in;
   logic [6:0]  entries_ff, entries_in;
   logic [6:0]  pin_ff, pin_in;
   logic [3:0]  d1_ff, d1_in;
   logic [3:0]  pin_ones_ff, pin_ones_in;
   logic [3:0]  mode_ff, mode_in;
   logic        minus_ff, minus_in;
   logic [6:0]  tally_ff, tally_in;
   logic [FW-1:0] slot_ff, slot_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic        over_ff, over_in;
   logic [2:0]  digs_ff, digs_in;
   logic        await_ff, await_in;
   logic [7:0]  cb_ff [8];
   logic [7:0]  cb_in [8];
   logic [3:0]  cb_cnt_ff, cb_cnt_in;
   logic        act_ed_ff, act_ed_in;
   logic        nrd_ff, nrd_in;
   logic        neg_ff, neg_in;
   logic [4:0]  ch_ff, ch_in;
   logic [FW-1:0] fidx_ff, fidx_in;

   logic          out_valid_ff;
   rsp_type       out_ff;
   logic          out_free, load;
   rsp_type       pl;

   logic [7:0]    resp_mem [RESP_DEPTH];
   logic          rm_we;
   logic [AW-1:0] rm_wa;
   logic [7:0]    rm_wd;
   logic [7:0]    rm_rdata_ff;

   logic [15:0]    chan_mem [CHAN_COUNT];
   logic [CHAN_COUNT-1:0] cvalid_ff;
   logic           cm_we, cm_re;
   logic [CIW-1:0] cm_wa, cm_ra;
   logic [15:0]    cm_wd;
   logic [15:0]    cm_rdata_ff;

   logic        conv_start, conv_done;
   logic [15:0] conv_val;
   logic [19:0] conv_digits;

   aspci_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (conv_val),
      .done   (conv_done),
      .digits (conv_digits)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // tens and ones digits of a small value, tens wrapped to one digit
   function automatic logic [7:0] split7(input logic [6:0] v);
      logic [3:0] t;
      logic [6:0] r;
      t = '0;
      for (int k = 1; k < 13; k++) begin
         if (v >= 7'(k * 10)) t = 4'(k);
      end
      r = v - 7'(t) * 7'd10;
      if (t >= 4'd10) t = t - 4'd10;
      return {t, r[3:0]};
   endfunction

   function automatic logic pin_free(input logic [6:0] p);
      return (32'(p) < PIN_COUNT) && !lock_mask[p[5:0]];
   endfunction

   function automatic logic [7:0] dchar(input logic [3:0] dv);
      return CH_ZERO + {4'b0, dv};
   endfunction

   always_comb begin
      logic [3:0]  d;
      logic [7:0]  b;
      logic [6:0]  ent, p;
      logic [16:0] acc10;
      logic [15:0] raw, mag, nv;
      logic [7:0]  sp;
      logic [FW:0] slot1;
      logic [4:0]  rdch;
      logic        ed_req, ed_dec, nval_req;

      b     = item.rx_byte;
      d     = (b >= CH_ZERO && b <= CH_NINE) ? 4'(b - CH_ZERO) : 4'd0;
      ent   = 7'(acc_ff) + 7'(d);
      p     = ent;
      acc10 = acc_ff * 17'd10 + 17'(d);
      raw   = '0;
      mag   = '0;
      nv    = '0;
      sp    = '0;
      slot1 = {1'b0, slot_ff} + (FW+1)'(1);
      rdch  = (item.op == OP_CREAD) ? item.chan_index : pin_ff[4:0];
      ed_req   = 1'b0;
      ed_dec   = 1'b0;
      nval_req = 1'b0;

      phase_in    = phase_ff;
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      acc_in      = acc_ff;
      entries_in  = entries_ff;
      pin_in      = pin_ff;
      d1_in       = d1_ff;
      pin_ones_in = pin_ones_ff;
      mode_in     = mode_ff;
      minus_in    = minus_ff;
      tally_in    = tally_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      over_in     = over_ff;
      digs_in     = digs_ff;
      await_in    = await_ff;
      cb_in       = cb_ff;
      cb_cnt_in   = cb_cnt_ff;
      act_ed_in   = act_ed_ff;
      nrd_in      = nrd_ff;
      neg_in      = neg_ff;
      ch_in       = ch_ff;
      fidx_in     = fidx_ff;

      item_pop   = 1'b0;
      load       = 1'b0;
      pl         = '0;
      rm_we      = 1'b0;
      rm_wa      = fill_ff[AW-1:0];
      rm_wd      = cb_ff[0];
      cm_we      = 1'b0;
      cm_re      = 1'b0;
      cm_wa      = item.chan_index[CIW-1:0];
      cm_wd      = item.chan_data;
      cm_ra      = rdch[CIW-1:0];
      conv_start = 1'b0;
      conv_val   = '0;

      case (state_ff)
         XS_IDLE: begin
            cm_re = 1'b1;
            if (item_valid && out_free) begin
               item_pop = 1'b1;
               case (item.op)
                  OP_BYTE: begin
                     if (!await_ff) begin
                        if (b == CH_NL) begin
                           fidx_in  = '0;
                           state_in = (fill_ff == '0) ? XS_FLNL : XS_FLADDR;
                        end else begin
                           case (phase_ff)
                              PH_HDR: begin
                                 if (b == CH_S_UP || b == CH_S_LO) begin
                                    cmd_in = CMD_S; phase_in = PH_CNT1;
                                 end else if (b == CH_W_UP || b == CH_W_LO) begin
                                    cmd_in = CMD_W; phase_in = PH_CNT1;
                                 end else if (b == CH_R_UP || b == CH_R_LO) begin
                                    cmd_in = CMD_R; phase_in = PH_CNT1;
                                 end else if (b == CH_N_UP || b == CH_N_LO) begin
                                    cmd_in = CMD_N; phase_in = PH_CNT1;
                                 end else if (b != CH_SP && b != CH_TAB) begin
                                    phase_in = PH_SKIP;
                                 end
                              end
                              PH_CNT1, PH_PIN1: begin
                                 acc_in   = 17'(d) * 17'd10;
                                 d1_in    = d;
                                 phase_in = (phase_ff == PH_CNT1) ? PH_CNT2 : PH_PIN2;
                              end
                              PH_CNT2: begin
                                 entries_in = ent;
                                 phase_in   = (ent == 7'd0) ? PH_HDR : PH_PIN1;
                                 if (cmd_ff == CMD_R) begin
                                    cb_in[0]  = CH_R_UP;
                                    cb_in[1]  = dchar(d1_ff);
                                    cb_in[2]  = dchar(d);
                                    cb_cnt_in = 4'd3;
                                    act_ed_in = 1'b0;
                                    state_in  = XS_APPEND;
                                 end else if (cmd_ff == CMD_N) begin
                                    cb_in[0]  = CH_N_UP;
                                    cb_in[1]  = CH_ZERO;
                                    cb_in[2]  = CH_ZERO;
                                    cb_cnt_in = 4'd3;
                                    act_ed_in = 1'b0;
                                    tally_in  = '0;
                                    slot_in   = (fill_ff < DEPTH) ? fill_ff + FW'(1) : fill_ff;
                                    state_in  = XS_APPEND;
                                 end
                              end
                              PH_PIN2: begin
                                 if (cmd_ff == CMD_N) p = {2'b0, ent[4:0]};
                                 pin_in      = p;
                                 pin_ones_in = d;
                                 phase_in    = PH_MODE;
                              end
                              PH_MODE: begin
                                 mode_in = d;
                                 case (cmd_ff)
                                    CMD_S: begin
                                       if (d <= 4'd2 && pin_free(pin_ff)) begin
                                          load     = 1'b1;
                                          pl.kind  = KIND_MODE;
                                          pl.pin   = pin_ff;
                                          pl.level = 8'(d);
                                          pl.last  = 1'b1;
                                       end
                                       ed_req = 1'b1;
                                    end
                                    CMD_W: begin
                                       if (d <= 4'd1) begin
                                          digs_in  = (d == 4'd0) ? 3'd1 : 3'd3;
                                          acc_in   = '0;
                                          phase_in = PH_WVAL;
                                       end else begin
                                          ed_req = 1'b1;
                                       end
                                    end
                                    CMD_R: begin
                                       cb_in[0]  = dchar(d1_ff);
                                       cb_in[1]  = dchar(pin_ones_ff);
                                       cb_cnt_in = 4'd2;
                                       state_in  = XS_APPEND;
                                       if (d <= 4'd1) begin
                                          load      = 1'b1;
                                          pl.kind   = (d == 4'd0) ? KIND_DREAD : KIND_AREAD;
                                          pl.pin    = pin_ff;
                                          pl.last   = 1'b1;
                                          await_in  = 1'b1;
                                          act_ed_in = 1'b0;
                                       end else begin
                                          act_ed_in = 1'b1;
                                       end
                                    end
                                    default: begin
                                       if (d == 4'd0) begin
                                          tally_in = tally_ff + 7'd1;
                                          ch_in    = pin_ff[4:0];
                                          nrd_in   = 1'b1;
                                          state_in = XS_CHRD;
                                       end else begin
                                          minus_in = 1'b0;
                                          acc_in   = '0;
                                          digs_in  = 3'd5;
                                          phase_in = PH_NSIGN;
                                       end
                                    end
                                 endcase
                              end
                              PH_WVAL: begin
                                 acc_in  = acc10;
                                 digs_in = digs_ff - 3'd1;
                                 if (digs_ff == 3'd1) begin
                                    if (pin_free(pin_ff)) begin
                                       load   = 1'b1;
                                       pl.pin = pin_ff;
                                       pl.last = 1'b1;
                                       if (mode_ff == 4'd0) begin
                                          pl.kind  = KIND_DWRITE;
                                          pl.level = 8'(acc10 != '0);
                                       end else begin
                                          pl.kind  = KIND_PWM;
                                          pl.level = (acc10 > 17'(PWM_MAX)) ? PWM_MAX
                                                                            : acc10[7:0];
                                       end
                                    end
                                    ed_req = 1'b1;
                                 end
                              end
                              PH_NSIGN: begin
                                 phase_in = PH_NVAL;
                                 if (b == CH_MINUS) minus_in = 1'b1;
                                 else nval_req = 1'b1;
                              end
                              PH_NVAL: begin
                                 nval_req = 1'b1;
                              end
                              default: begin
                              end
                           endcase
                        end
                     end
                  end
                  OP_SAMPLE: begin
                     if (await_ff) begin
                        await_in = 1'b0;
                        if (mode_ff == 4'd0) begin
                           cb_in[0]  = CH_ZERO + 8'(item.sample != '0);
                           cb_cnt_in = 4'd1;
                           act_ed_in = 1'b1;
                           state_in  = XS_APPEND;
                        end else begin
                           conv_start = 1'b1;
                           conv_val   = 16'(item.sample);
                           nrd_in     = 1'b0;
                           state_in   = XS_CONV;
                        end
                     end
                  end
                  OP_CWRITE: begin
                     if ({1'b0, item.chan_index} < CC6) cm_we = 1'b1;
                  end
                  default: begin
                     ch_in    = item.chan_index;
                     nrd_in   = 1'b0;
                     state_in = XS_CHRD;
                  end
               endcase
            end
         end
         XS_CHRD: begin
            if ({1'b0, ch_ff} < CC6 && cvalid_ff[ch_ff[CIW-1:0]]) raw = cm_rdata_ff;
            if (!nrd_ff) begin
               if (out_free) begin
                  load        = 1'b1;
                  pl.kind     = KIND_CHAN;
                  pl.chan_out = raw;
                  pl.last     = 1'b1;
                  state_in    = XS_IDLE;
               end
            end else begin
               mag        = raw[15] ? 16'(16'd0 - raw) : raw;
               neg_in     = raw[15];
               conv_start = 1'b1;
               conv_val   = mag;
               state_in   = XS_CONV;
            end
         end
         XS_CONV: begin
            if (conv_done) begin
               act_ed_in = 1'b1;
               state_in  = XS_APPEND;
               if (nrd_ff) begin
                  sp       = split7({2'b0, ch_ff});
                  cb_in[0] = dchar(sp[7:4]);
                  cb_in[1] = dchar(sp[3:0]);
                  if (neg_ff) begin
                     cb_in[2] = CH_MINUS;
                     for (int k = 0; k < 5; k++) cb_in[3+k] = dchar(conv_digits[4*(4-k) +: 4]);
                     cb_cnt_in = 4'd8;
                  end else begin
                     for (int k = 0; k < 5; k++) cb_in[2+k] = dchar(conv_digits[4*(4-k) +: 4]);
                     cb_cnt_in = 4'd7;
                  end
               end else begin
                  for (int k = 0; k < 4; k++) cb_in[k] = dchar(conv_digits[4*(3-k) +: 4]);
                  cb_cnt_in = 4'd4;
               end
            end
         end
         XS_APPEND: begin
            if (cb_cnt_ff != 4'd0) begin
               if (fill_ff < DEPTH) begin
                  rm_we   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end else begin
                  over_in = 1'b1;
               end
               for (int k = 0; k < 7; k++) cb_in[k] = cb_ff[k+1];
               cb_cnt_in = cb_cnt_ff - 4'd1;
            end else begin
               state_in = XS_IDLE;
               ed_req   = act_ed_ff;
            end
         end
         XS_PATCH1: begin
            sp    = split7(tally_ff);
            rm_wa = slot_ff[AW-1:0];
            rm_wd = dchar(sp[7:4]);
            rm_we = (slot_ff < fill_ff);
            state_in = XS_PATCH2;
         end
         XS_PATCH2: begin
            sp    = split7(tally_ff);
            rm_wa = slot1[AW-1:0];
            rm_wd = dchar(sp[3:0]);
            rm_we = (slot1 < {1'b0, fill_ff});
            ed_dec   = 1'b1;
            state_in = XS_IDLE;
         end
         XS_FLADDR: begin
            state_in = XS_FLDATA;
         end
         XS_FLDATA: begin
            if (out_free) begin
               load         = 1'b1;
               pl.tx_byte   = rm_rdata_ff;
               pl.truncated = over_ff;
               fidx_in      = fidx_ff + FW'(1);
               state_in     = (fidx_in == fill_ff) ? XS_FLNL : XS_FLADDR;
            end
         end
         XS_FLNL: begin
            if (out_free) begin
               load         = 1'b1;
               pl.tx_byte   = CH_NL;
               pl.truncated = over_ff;
               pl.last      = 1'b1;
               fill_in      = '0;
               over_in      = 1'b0;
               phase_in     = PH_HDR;
               entries_in   = '0;
               state_in     = XS_IDLE;
            end
         end
         default: begin
            state_in = XS_IDLE;
         end
      endcase

      // numeric channel write digit
      if (nval_req) begin
         acc_in  = acc10;
         digs_in = digs_ff - 3'd1;
         if (digs_ff == 3'd1) begin
            nv = minus_ff ? 16'(16'd0 - acc10[15:0]) : acc10[15:0];
            cm_wa = pin_ff[CIW-1:0];
            cm_wd = nv;
            cm_we = ({1'b0, pin_ff[4:0]} < CC6);
            ed_req = 1'b1;
         end
      end

      // end of one entry, the count echo is patched first for N
      if (ed_req && cmd_ff == CMD_N) begin
         state_in = XS_PATCH1;
      end else if (ed_req || ed_dec) begin
         entries_in = entries_ff - 7'(entries_ff != 7'd0);
         phase_in   = (entries_in == 7'd0) ? PH_HDR : PH_PIN1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         state_ff     <= XS_IDLE;
         cmd_ff       <= CMD_S;
         acc_ff       <= '0;
         entries_ff   <= '0;
         pin_ff       <= '0;
         mode_ff      <= '0;
         minus_ff     <= 1'b0;
         tally_ff     <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         over_ff      <= 1'b0;
         digs_ff      <= '0;
         await_ff     <= 1'b0;
         cb_cnt_ff    <= '0;
         act_ed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         cvalid_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         acc_ff       <= acc_in;
         entries_ff   <= entries_in;
         pin_ff       <= pin_in;
         mode_ff      <= mode_in;
         minus_ff     <= minus_in;
         tally_ff     <= tally_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         over_ff      <= over_in;
         digs_ff      <= digs_in;
         await_ff     <= await_in;
         cb_cnt_ff    <= cb_cnt_in;
         act_ed_ff    <= act_ed_in;
         out_valid_ff <= load || (out_valid_ff && rsp_stall);
         if (cm_we) cvalid_ff[cm_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff       <= d1_in;
      pin_ones_ff <= pin_ones_in;
      cb_ff       <= cb_in;
      nrd_ff      <= nrd_in;
      neg_ff      <= neg_in;
      ch_ff       <= ch_in;
      fidx_ff     <= fidx_in;
      if (load) out_ff <= pl;
   end

   always_ff @(posedge clock) begin
      if (rm_we) resp_mem[rm_wa] <= rm_wd;
      rm_rdata_ff <= resp_mem[fidx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cm_we) chan_mem[cm_wa] <= cm_wd;
      if (cm_re) cm_rdata_ff <= chan_mem[cm_ra];
   end

endmodule
`default_nettype wire

// ----- sv/ascii_pin_command_interpreter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_pin_command_interpreter
// Parses a serial command line and turns it into pin actions and responses.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one input beat (received byte, sample reply, local channel
//  write or read), taken when req_valid is high and req_stall low. Beats go
//  into a two-entry queue, so the next beat is taken while a result waits.
//  rsp_* carries result beats; rsp_data.last marks the final beat of an item.
//  csr_* writes the 64-bit pin lock mask; csr_ready is always high.
//  Flow: a beat passes the queue slot and the executor, and its result leaves
//  through the output register. A plain byte is handled in the idle state;
//  response characters are appended one at a time in the append state; a
//  number echo also passes the bit-serial decimal converter; an N entry adds
//  the count patching states. A newline flush sends each stored byte as a
//  read of the response memory and then an output beat, and ends with the
//  newline.
//  Reset clears the parser, the fill count, the lock mask and the channel
//  valid bits at once; no clearing pass is needed.
//  While rsp_stall is high the result is held and the executor waits; the
//  queue fills and then raises req_stall.
// ----------------------------------------------------------------------------
module ascii_pin_command_interpreter
   import aspci_pkg::*;
#(
   parameter int RESP_DEPTH = RESP_DEPTH_DEF,
   parameter int CHAN_COUNT = CHAN_COUNT_DEF,
   parameter int PIN_COUNT  = PIN_COUNT_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  req_type     req_data,
   output logic        req_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        rsp_stall,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   logic [63:0] lock_ff;
   logic        q_valid, q_pop;
   req_type     q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         lock_ff <= csr_data;
      end
   end

   aspci_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_data  (req_data),
      .push_stall (req_stall),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   aspci_exec #(
      .RESP_DEPTH (RESP_DEPTH),
      .CHAN_COUNT (CHAN_COUNT),
      .PIN_COUNT  (PIN_COUNT)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_data),
      .item_pop   (q_pop),
      .lock_mask  (lock_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

   a_pop_needs_beat: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("executor popped an empty queue");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !req_stall)
      else $error("input stalled while queue empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_valid)
      else $error("beats survive reset");

endmodule
`default_nettype wire
